[rtl/core/ffba_pkg.sv]
// Shared types and status codes for the first-fit block allocator.
package ffba_pkg;

  localparam logic [7:0] NO_OWNER = 8'hFF;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_ZERO_REQ  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FREED     = 3'd3,
    ST_BAD_PTR   = 3'd4,
    ST_NOT_START = 3'd5
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [15:0] request_size;
    logic [7:0]  owner_id;
    logic [0:0]  pointer_is_null;
    logic [15:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] data_offset;
    logic [15:0] granted_size;
  } out_item_t;

  // One row of the block table.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        free;
    logic [7:0]  owner;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    wr_exact;
    logic    shift_init;
    logic    shift;
    logic    wr_new;
    logic    wr_own;
    logic    merge_init;
    logic    merge;
    logic    emit;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic in_bad;
    logic in_free;
    logic op_free;
    logic hit;
    logic hit_exact;
    logic scan_end;
    logic shift_done;
    logic merge_done;
  } stat_t;

endpackage

[rtl/core/first_fit_block_allocator_top.sv]
// Top level of the first-fit block allocator: controller plus table datapath.
// Zero-size allocations and null or out-of-arena frees answer from the idle state, with no scan.
// Other requests scan the table at one entry per cycle; a split then shifts the entries
// after the hit and writes the new free block and the owned block, and a free adds a
// merge pass over the table. One request at a time; busy is high while it runs.
// Reset is synchronous and leaves one free block covering the arena; no clearing pass.
module first_fit_block_allocator_top #(
  parameter int ARENA_BYTES  = 8192,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ffba_pkg::out_item_t out_data
);

  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t st;

  // The controller sequences scan, shift, split writes and the merge pass.
  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // The datapath owns the block table memory and the result register.
  ffba_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/core/ffba_ctrl.sv]
// Sequencing state machine of the first-fit block allocator.
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ffba_pkg::stat_t st,
  output ffba_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SCAN      = 7'b0000010,
    S_SHIFT     = 7'b0000100,
    S_SPLIT_NEW = 7'b0001000,
    S_SPLIT_OWN = 7'b0010000,
    S_MERGE     = 7'b0100000,
    S_SPARE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.code = ffba_pkg::ST_ALLOCATED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!st.in_free && st.in_zero) begin
            cmd.emit = 1'b1;
            cmd.code = ffba_pkg::ST_ZERO_REQ;
          end else if (st.in_free && st.in_bad) begin
            cmd.emit = 1'b1;
            cmd.code = ffba_pkg::ST_BAD_PTR;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          if (st.op_free) begin
            cmd.merge_init = 1'b1;
            state_nxt      = S_MERGE;
          end else if (st.hit_exact) begin
            cmd.wr_exact = 1'b1;
            cmd.emit     = 1'b1;
            cmd.code     = ffba_pkg::ST_ALLOCATED;
            state_nxt    = S_IDLE;
          end else begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end
        end else if (st.scan_end) begin
          cmd.emit  = 1'b1;
          cmd.code  = st.op_free ? ffba_pkg::ST_NOT_START : ffba_pkg::ST_NO_FIT;
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_done) begin
          state_nxt = S_SPLIT_NEW;
        end
      end
      S_SPLIT_NEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_SPLIT_OWN;
      end
      S_SPLIT_OWN: begin
        cmd.wr_own = 1'b1;
        cmd.emit   = 1'b1;
        cmd.code   = ffba_pkg::ST_ALLOCATED;
        state_nxt  = S_IDLE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (st.merge_done) begin
          cmd.emit  = 1'b1;
          cmd.code  = ffba_pkg::ST_FREED;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ffba_dp.sv]
// Block table memory, scan, shift and merge datapath of the allocator.
module ffba_dp #(
  parameter int ARENA_BYTES  = 8192,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_pkg::in_item_t  in_data,
  input  ffba_pkg::cmd_t      cmd,
  output ffba_pkg::stat_t     st,
  output logic                out_valid,
  output ffba_pkg::out_item_t out_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [16:0] HDR17   = 17'(HEADER_BYTES);
  localparam logic [17:0] HDR18   = 18'(HEADER_BYTES);
  localparam logic [16:0] ARENA17 = 17'(ARENA_BYTES);
  localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);

  ffba_pkg::entry_t mem [MAX_BLOCKS];

  ffba_pkg::entry_t reset_ent;
  ffba_pkg::entry_t rd_q_r, rd_ent, ent;
  ffba_pkg::entry_t hit_ent_r, acc_r, wr_data;
  logic             rd_e0_r, e0_init_r;
  logic [AW-1:0]    rd_addr, wr_addr, chk_idx_r, hit_idx_r, wa_r, wptr_r;
  logic             wr_en;
  logic [CW-1:0]    count_r, idx_r, sh_r;
  logic             chk_v_r, wv_r, acc_v_r;
  logic             op_free_r;
  logic [16:0]      need_r;
  logic [7:0]       owner_r;
  logic [15:0]      off_r;
  logic             issue, sh_issue, match, exact;
  logic             out_valid_r;
  ffba_pkg::out_item_t out_data_r;

  assign reset_ent.start = '0;
  assign reset_ent.size  = 16'(ARENA_BYTES - HEADER_BYTES);
  assign reset_ent.free  = 1'b1;
  assign reset_ent.owner = ffba_pkg::NO_OWNER;

  // Entry zero reads as its reset value until it is first written.
  assign rd_ent = rd_e0_r ? reset_ent : rd_q_r;

  always_comb begin
    ent = rd_ent;
    if (cmd.merge && chk_idx_r == hit_idx_r) begin
      ent.free  = 1'b1;
      ent.owner = ffba_pkg::NO_OWNER;
    end
  end

  assign issue    = (idx_r < count_r);
  assign sh_issue = (sh_r > CW'(hit_idx_r));
  assign rd_addr  = cmd.shift ? sh_r[AW-1:0] : idx_r[AW-1:0];

  assign exact = ({1'b0, rd_ent.size} == need_r);
  always_comb begin
    if (op_free_r) begin
      match = ({1'b0, rd_ent.start} + HDR17) == {1'b0, off_r};
    end else begin
      match = rd_ent.free &&
              (exact || (({2'b0, rd_ent.size} > ({1'b0, need_r} + HDR18)) &&
                         (count_r < MAXC)));
    end
  end

  assign st.in_zero    = (in_data.request_size == 16'd0);
  assign st.in_bad     = in_data.pointer_is_null[0] ||
                         ({1'b0, in_data.free_offset} >= ARENA17);
  assign st.in_free    = (in_data.opcode == ffba_pkg::OP_FREE);
  assign st.op_free    = op_free_r;
  assign st.hit        = chk_v_r && match;
  assign st.hit_exact  = exact;
  assign st.scan_end   = !chk_v_r && !issue;
  assign st.shift_done = !sh_issue && !wv_r;
  assign st.merge_done = !chk_v_r && !issue;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = hit_ent_r;
    if (cmd.wr_exact) begin
      wr_en         = 1'b1;
      wr_addr       = chk_idx_r;
      wr_data       = rd_ent;
      wr_data.free  = 1'b0;
      wr_data.owner = owner_r;
    end else if (cmd.shift && wv_r) begin
      wr_en   = 1'b1;
      wr_addr = wa_r;
      wr_data = rd_ent;
    end else if (cmd.wr_new) begin
      wr_en         = 1'b1;
      wr_addr       = hit_idx_r + AW'(1);
      wr_data.start = hit_ent_r.start + HDR17[15:0] + need_r[15:0];
      wr_data.size  = hit_ent_r.size - need_r[15:0] - HDR17[15:0];
      wr_data.free  = 1'b1;
      wr_data.owner = ffba_pkg::NO_OWNER;
    end else if (cmd.wr_own) begin
      wr_en         = 1'b1;
      wr_addr       = hit_idx_r;
      wr_data.size  = need_r[15:0];
      wr_data.free  = 1'b0;
      wr_data.owner = owner_r;
    end else if (cmd.merge && acc_v_r) begin
      if (chk_v_r && !(acc_r.free && ent.free)) begin
        wr_en   = 1'b1;
        wr_addr = wptr_r;
        wr_data = acc_r;
      end else if (!chk_v_r && !issue) begin
        wr_en   = 1'b1;
        wr_addr = wptr_r;
        wr_data = acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_init_r   <= 1'b1;
      rd_e0_r     <= 1'b0;
      count_r     <= CW'(1);
      chk_v_r     <= 1'b0;
      wv_r        <= 1'b0;
      acc_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_e0_r <= e0_init_r && (rd_addr == '0);
      if (wr_en && wr_addr == '0) begin
        e0_init_r <= 1'b0;
      end
      out_valid_r <= cmd.emit;
      if (cmd.load || cmd.merge_init) begin
        chk_v_r <= 1'b0;
        acc_v_r <= 1'b0;
      end else if (cmd.scan || cmd.merge) begin
        chk_v_r <= issue;
        if (cmd.merge && chk_v_r) begin
          acc_v_r <= 1'b1;
        end
      end
      if (cmd.shift_init) begin
        wv_r <= 1'b0;
      end else if (cmd.shift) begin
        wv_r <= sh_issue;
      end
      if (cmd.wr_own) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.merge && !chk_v_r && !issue) begin
        count_r <= CW'(wptr_r) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_free_r <= in_data.opcode[0];
      need_r    <= ({1'b0, in_data.request_size} + 17'd7) & ~17'd7;
      owner_r   <= in_data.owner_id;
      off_r     <= in_data.free_offset;
      idx_r     <= '0;
    end else if (cmd.merge_init) begin
      idx_r  <= '0;
      wptr_r <= '0;
    end else if ((cmd.scan || cmd.merge) && issue) begin
      idx_r <= idx_r + CW'(1);
    end
    if ((cmd.scan || cmd.merge) && issue) begin
      chk_idx_r <= idx_r[AW-1:0];
    end
    if (cmd.scan && chk_v_r && match) begin
      hit_idx_r <= chk_idx_r;
      hit_ent_r <= rd_ent;
    end
    if (cmd.shift_init) begin
      sh_r <= count_r - CW'(1);
    end else if (cmd.shift && sh_issue) begin
      sh_r <= sh_r - CW'(1);
      wa_r <= sh_r[AW-1:0] + AW'(1);
    end
    // Merge pass: fold runs of free blocks into the accumulated block.
    if (cmd.merge && chk_v_r) begin
      if (!acc_v_r) begin
        acc_r <= ent;
      end else if (acc_r.free && ent.free) begin
        acc_r.size <= acc_r.size + ent.size + HDR17[15:0];
      end else begin
        acc_r  <= ent;
        wptr_r <= wptr_r + AW'(1);
      end
    end
    if (cmd.emit) begin
      out_data_r.status <= cmd.code;
      if (cmd.code == ffba_pkg::ST_ALLOCATED) begin
        out_data_r.data_offset  <= (cmd.wr_exact ? rd_ent.start : hit_ent_r.start) +
                                   HDR17[15:0];
        out_data_r.granted_size <= need_r[15:0];
      end else begin
        out_data_r.data_offset  <= '0;
        out_data_r.granted_size <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[verif/first_fit_block_allocator_checker.sv]
// Checker for the first-fit block allocator: table predictor and result comparison.
module first_fit_block_allocator_checker #(
  parameter int ARENA_BYTES  = 8192,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  ffba_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  ffba_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import ffba_pkg::*;

  int unsigned tbl_start [MAX_BLOCKS];
  int unsigned tbl_size  [MAX_BLOCKS];
  bit          tbl_free  [MAX_BLOCKS];
  logic [7:0]  tbl_owner [MAX_BLOCKS];
  int unsigned tbl_count;
  out_item_t   expected_q[$];

  function automatic void table_reset();
    tbl_start[0] = 0;
    tbl_size[0]  = ARENA_BYTES - HEADER_BYTES;
    tbl_free[0]  = 1'b1;
    tbl_owner[0] = NO_OWNER;
    tbl_count    = 1;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_size[k]  = tbl_size[k+1];
      tbl_free[k]  = tbl_free[k+1];
      tbl_owner[k] = tbl_owner[k+1];
    end
    tbl_count--;
  endfunction

  // Applies one request to the table copy and returns the answer it should get.
  function automatic out_item_t allocate_or_free(in_item_t req);
    out_item_t   res;
    int unsigned need;
    int unsigned i;
    res = '0;
    if (req.opcode == OP_ALLOC) begin
      if (req.request_size == 0) begin
        res.status = ST_ZERO_REQ;
      end else begin
        need = (int'(req.request_size) + 7) & ~32'd7;
        res.status = ST_NO_FIT;
        for (i = 0; i < tbl_count; i++) begin
          if (!tbl_free[i]) continue;
          if (tbl_size[i] == need) begin
            tbl_free[i]  = 1'b0;
            tbl_owner[i] = req.owner_id;
            res.status = ST_ALLOCATED;
            break;
          end
          if (tbl_size[i] > need + HEADER_BYTES && tbl_count < MAX_BLOCKS) begin
            for (int unsigned k = tbl_count; k > i + 1; k--) begin
              tbl_start[k] = tbl_start[k-1];
              tbl_size[k]  = tbl_size[k-1];
              tbl_free[k]  = tbl_free[k-1];
              tbl_owner[k] = tbl_owner[k-1];
            end
            tbl_count++;
            tbl_start[i+1] = tbl_start[i] + HEADER_BYTES + need;
            tbl_size[i+1]  = tbl_size[i] - need - HEADER_BYTES;
            tbl_free[i+1]  = 1'b1;
            tbl_owner[i+1] = NO_OWNER;
            tbl_size[i]    = need;
            tbl_free[i]    = 1'b0;
            tbl_owner[i]   = req.owner_id;
            res.status = ST_ALLOCATED;
            break;
          end
        end
        if (res.status == ST_ALLOCATED) begin
          res.data_offset  = 16'(tbl_start[i] + HEADER_BYTES);
          res.granted_size = 16'(need);
        end
      end
    end else if (req.pointer_is_null || req.free_offset >= ARENA_BYTES) begin
      res.status = ST_BAD_PTR;
    end else begin
      res.status = ST_NOT_START;
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_start[i] + HEADER_BYTES == req.free_offset) begin
          tbl_free[i]  = 1'b1;
          tbl_owner[i] = NO_OWNER;
          res.status = ST_FREED;
          i = 0;
          while (i + 1 < tbl_count) begin
            if (tbl_free[i] && tbl_free[i+1]) begin
              tbl_size[i] = tbl_size[i] + tbl_size[i+1] + HEADER_BYTES;
              drop_entry(i + 1);
            end else begin
              i++;
            end
          end
          break;
        end
      end
    end
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst_n) begin
      table_reset();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) expected_q.push_back(allocate_or_free(in_data));
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (exp_res !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected %p, got %p", exp_res, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[verif/first_fit_block_allocator_top_tb.sv]
// Testbench top for the first-fit block allocator: stimulus, clock, reset and verdict.
module first_fit_block_allocator_top_tb;
  import ffba_pkg::*;

  localparam int ARENA  = 8192;
  localparam int HDR    = 24;
  localparam int LIMIT  = 4000000;
  localparam int ITEM_W = $bits(in_item_t);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count = 0;

  // Offsets of data areas handed out so far; frees mostly target these.
  logic [15:0] live_offsets[$];

  always #5 clk = ~clk;

  first_fit_block_allocator_top #(.ARENA_BYTES(ARENA), .HEADER_BYTES(HDR), .MAX_BLOCKS(256))
  dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  first_fit_block_allocator_checker #(.ARENA_BYTES(ARENA), .HEADER_BYTES(HDR), .MAX_BLOCKS(256))
  checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  // Record granted offsets so later frees can hit real block starts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_data.status == ST_ALLOCATED)
      live_offsets.push_back(out_data.data_offset);
  end

  // The run is stopped by a cycle counter, so a hung handshake cannot stall it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one item: wait the random gap, raise start, hold until it is taken.
  // Start stays high after the accepting edge; a gap before the next item or the caller lowers it.
  task automatic send_item(input in_item_t item, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  function automatic in_item_t alloc_item(logic [15:0] size, logic [7:0] owner);
    in_item_t it;
    it = in_item_t'(ITEM_W'({$urandom, $urandom}));
    it.opcode = OP_ALLOC;
    it.request_size = size;
    it.owner_id = owner;
    return it;
  endfunction

  function automatic in_item_t free_item(logic [15:0] offset, logic null_ptr);
    in_item_t it;
    it = in_item_t'(ITEM_W'({$urandom, $urandom}));
    it.opcode = OP_FREE;
    it.pointer_is_null = null_ptr;
    it.free_offset = offset;
    return it;
  endfunction

  task automatic random_item();
    int pick;
    int idx;
    logic [15:0] sz;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // Mostly small sizes so the table fills with many blocks; a few huge ones.
      case ($urandom_range(0, 9))
        0:       sz = 16'($urandom);
        1:       sz = 16'($urandom_range(0, 8));
        2, 3:    sz = 16'($urandom_range(1, 1024));
        default: sz = 16'($urandom_range(1, 64));
      endcase
      send_item(alloc_item(sz, 8'($urandom)), 1'b1);
    end else if (pick < 88 && live_offsets.size() > 0) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      send_item(free_item(live_offsets[idx], 1'b0), 1'b1);
      // Keep a stale copy now and then so double frees also occur.
      if ($urandom_range(0, 4) != 0) live_offsets.delete(idx);
    end else if (pick < 94) begin
      send_item(free_item(16'($urandom_range(0, ARENA - 1)), 1'b0), 1'b1);
    end else begin
      send_item(free_item(16'($urandom), 1'($urandom)), 1'b1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corner sizes, every status, owner extremes, bad pointers.
    send_item(alloc_item(16'd0, 8'd1), 1'b0);
    send_item(alloc_item(16'hFFFF, 8'd2), 1'b0);
    send_item(alloc_item(16'd1, 8'd0), 1'b0);
    send_item(alloc_item(16'd8, 8'd255), 1'b0);
    send_item(alloc_item(16'd9, 8'd254), 1'b0);
    send_item(free_item(16'd0, 1'b1), 1'b0);
    send_item(free_item(16'hFFFF, 1'b0), 1'b0);
    send_item(free_item(16'(ARENA), 1'b0), 1'b0);
    send_item(free_item(16'(ARENA - 1), 1'b0), 1'b0);
    send_item(free_item(16'd25, 1'b0), 1'b0);
    send_item(free_item(16'd56, 1'b0), 1'b0);
    send_item(free_item(16'd56, 1'b0), 1'b0);
    send_item(free_item(16'd24, 1'b0), 1'b0);
    // Same size again splits the hole that the two frees merged.
    send_item(alloc_item(16'd8, 8'd7), 1'b0);
    // Take almost all of the arena, then a size no hole fits and an exact fit of a small hole.
    send_item(alloc_item(16'd8000, 8'd3), 1'b0);
    send_item(alloc_item(16'd48, 8'd4), 1'b0);
    send_item(alloc_item(16'd8, 8'd5), 1'b0);
    // A free at an offset that is no block's data start.
    send_item(free_item(16'd8120, 1'b0), 1'b0);

    // Let the table settle before the random part.
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (600) @(posedge clk);

    for (int n = 0; n < 1000; n++) begin
      random_item();
      if (n == 500) begin
        // Hold off until every expected result is back.
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (1200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/ffba_pkg.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dp.sv
rtl/core/first_fit_block_allocator_top.sv
verif/first_fit_block_allocator_checker.sv
verif/first_fit_block_allocator_top_tb.sv
